// File: rtl/htfd_pkg.sv
// ----------------------------------------------------------------------------
// htfd_pkg: shared types, constants and functions of the frame decoder
// CRC-8 step, status codes, frame byte positions and the scaled division
// by 65535 used for the fixed-point conversion.
// ----------------------------------------------------------------------------
package htfd_pkg;

	localparam logic [7:0]  CRC_INIT    = 8'hFF;
	localparam logic [7:0]  CRC_POLY    = 8'h31;
	localparam logic [14:0] TEMP_SCALE  = 15'd17500;
	localparam logic [14:0] TEMP_OFFSET = 15'd4500;
	localparam logic [13:0] HUM_SCALE   = 14'd10000;

	localparam logic [2:0] POS_T_MSB  = 3'd0;
	localparam logic [2:0] POS_T_LSB  = 3'd1;
	localparam logic [2:0] POS_T_CRC  = 3'd2;
	localparam logic [2:0] POS_RH_MSB = 3'd3;
	localparam logic [2:0] POS_RH_LSB = 3'd4;
	localparam logic [2:0] POS_RH_CRC = 3'd5;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_TEMP_CRC = 2'd1,
		STATUS_HUM_CRC  = 2'd2
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] temp_word;
		logic [15:0] hum_word;
	} frame_result_t;

	// CRC-8 over one byte, MSB first, no final XOR
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	// floor(x / 65535) for x below 2^31: x = q0*65536 + lo, so the remainder
	// against 65535 is lo + q0, which stays below twice the divisor
	function automatic logic [15:0] div_65535(input logic [30:0] x);
		logic [14:0] q0;
		logic [16:0] r;
		q0 = x[30:16];
		r  = {1'b0, x[15:0]} + {2'b00, q0};
		return {1'b0, q0} + {15'd0, (r >= 17'd65535)};
	endfunction

endpackage

// File: rtl/htfd_frame_parse.sv
// ----------------------------------------------------------------------------
// htfd_frame_parse: byte sequencer and CRC check of one measurement frame
// Tracks the byte position, runs the CRC over each word and assembles the
// raw words; flags the sixth byte and presents status and words for it.
// ----------------------------------------------------------------------------
module htfd_frame_parse import htfd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  logic [7:0]    rx_byte,
	input  logic          frame_start,
	output logic          done,
	output frame_result_t result
);

	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic [15:0] temp_word_q;
	logic        temp_good_q;
	logic [7:0]  hum_high_q;
	logic [7:0]  hum_low_q;

	logic [2:0]  pos;
	logic [7:0]  crc_next;
	logic        hum_good;

	// a start mark or an out-of-range position restarts the frame
	assign pos = (frame_start || pos_q > POS_RH_CRC) ? POS_T_MSB : pos_q;
	assign done = (pos == POS_RH_CRC);
	assign crc_next = crc8_byte((pos == POS_T_MSB || pos == POS_RH_MSB) ? CRC_INIT : crc_q,
		rx_byte);
	assign hum_good = (crc_q == rx_byte);

	always_comb begin
		result.temp_word = temp_word_q;
		result.hum_word  = {hum_high_q, hum_low_q};
		priority if (!temp_good_q) begin
			result.status = STATUS_TEMP_CRC;
		end else if (!hum_good) begin
			result.status = STATUS_HUM_CRC;
		end else begin
			result.status = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_T_MSB;
			crc_q       <= CRC_INIT;
			temp_word_q <= '0;
			temp_good_q <= 1'b0;
			hum_high_q  <= '0;
			hum_low_q   <= '0;
		end else if (fire) begin
			// wrap after the sixth byte
			pos_q <= (pos == POS_RH_CRC) ? POS_T_MSB : pos + 3'd1;
			unique case (pos)
				POS_T_MSB: begin
					crc_q       <= crc_next;
					temp_word_q <= {rx_byte, 8'h00};
				end
				POS_T_LSB: begin
					crc_q             <= crc_next;
					temp_word_q[7:0] <= rx_byte;
				end
				POS_T_CRC: begin
					temp_good_q <= (crc_q == rx_byte);
				end
				POS_RH_MSB: begin
					crc_q      <= crc_next;
					hum_high_q <= rx_byte;
				end
				POS_RH_LSB: begin
					crc_q     <= crc_next;
					hum_low_q <= rx_byte;
				end
				default: begin
					// frame complete: restart the CRC
					crc_q <= CRC_INIT;
				end
			endcase
		end
	end

endmodule

// File: rtl/humidity_temp_frame_decoder.sv
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder: measurement frame decoder with CRC check
// Three-stage pipeline: input register, frame parse and scale multiply,
// division by 65535 into the result register.
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle (T_MSB, T_LSB, T_CRC, RH_MSB,
// RH_LSB, RH_CRC) and gives one result after every sixth byte through the
// multiply stage and the result register. Bytes keep flowing while a result
// waits to be taken; the input stalls only when the sixth byte of the next
// frame finds the multiply stage full and the result stalled. Temperature
// is 17500*raw/65535 - 4500 in hundredths of a degree and humidity is
// 10000*raw/65535 in hundredths of a percent, both truncated and both zero
// when a CRC check fails. The rate is set by the byte-wide CRC step, one
// byte per cycle while the input is not stalled.
module humidity_temp_frame_decoder import htfd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	output logic               rx_stall,
	input  logic [7:0]         rx_byte,
	input  logic               frame_start,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [1:0]         status,
	output logic signed [14:0] temperature_centi,
	output logic [13:0]        humidity_centi,
	output logic [15:0]        temperature_word,
	output logic [15:0]        humidity_word
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          start_s1;

	logic          valid_s2;
	status_t       status_s2;
	logic [15:0]   temp_word_s2;
	logic [15:0]   hum_word_s2;
	logic [30:0]   temp_prod_s2;
	logic [29:0]   hum_prod_s2;

	logic          out_load;
	logic          s2_ready;
	logic          s1_done;
	logic          s1_fire;
	frame_result_t frame;

	logic [15:0]   temp_q;
	logic [15:0]   hum_q;

	assign out_load = !result_valid || !result_stall;
	assign s2_ready = !valid_s2 || out_load;
	assign rx_stall = valid_s1 && s1_done && !s2_ready;
	assign s1_fire  = valid_s1 && (!s1_done || s2_ready);

	htfd_frame_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (s1_fire),
		.rx_byte     (byte_s1),
		.frame_start (start_s1),
		.done        (s1_done),
		.result      (frame)
	);

	assign temp_q = div_65535(temp_prod_s2);
	assign hum_q  = div_65535({1'b0, hum_prod_s2});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (!rx_stall) begin
				valid_s1 <= rx_valid;
			end
			if (s2_ready) begin
				valid_s2 <= s1_fire && s1_done;
			end
			if (out_load) begin
				result_valid <= valid_s2;
			end
		end
	end

	// payload registers: load only when the stage takes a new request
	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1  <= rx_byte;
			start_s1 <= frame_start;
		end
		if (s1_fire && s1_done && s2_ready) begin
			status_s2    <= frame.status;
			temp_word_s2 <= frame.temp_word;
			hum_word_s2  <= frame.hum_word;
			temp_prod_s2 <= 31'(frame.temp_word) * 31'(TEMP_SCALE);
			hum_prod_s2  <= 30'(frame.hum_word) * 30'(HUM_SCALE);
		end
		if (valid_s2 && out_load) begin
			status           <= status_s2;
			temperature_word <= temp_word_s2;
			humidity_word    <= hum_word_s2;
			if (status_s2 == STATUS_OK) begin
				temperature_centi <= signed'(temp_q[14:0] - TEMP_OFFSET);
				humidity_centi    <= hum_q[13:0];
			end else begin
				temperature_centi <= '0;
				humidity_centi    <= '0;
			end
		end
	end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the humidity/temperature frame decoder
// Six-byte measurement frames go in through the valid/stall byte port. A
// local byte-by-byte decoder predicts each reading. Every reading taken
// from the result port is compared field by field with the oldest
// prediction. A short table of hand-built frames runs first. Random frames,
// broken frames and stray bytes follow under three idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
	import htfd_pkg::*;

	localparam int RANDOM_PER_PHASE = 406;
	localparam int SETTLE_CYCLES    = 8;
	localparam int WATCHDOG_LIMIT   = 2000;

	typedef struct packed {
		status_t            status;
		logic signed [14:0] temp_c;
		logic [13:0]        hum_c;
		logic [15:0]        temp_bits;
		logic [15:0]        hum_raw;
	} reading_t;

	typedef struct packed {
		logic [15:0] t_word;
		logic [15:0] h_word;
		bit          bad_t;
		bit          bad_h;
		bit          mark;
		logic [2:0]  nbytes;
		bit          pinned;
		reading_t    pin_reading;
	} frame_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               rx_valid = 1'b0;
	logic               rx_stall;
	logic [7:0]         rx_byte = 8'h00;
	logic               frame_start = 1'b0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [1:0]         status;
	logic signed [14:0] temperature_centi;
	logic [13:0]        humidity_centi;
	logic [15:0]        temperature_word;
	logic [15:0]        humidity_word;

	// decoder state mirrored by the predictor
	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic [15:0] t_raw_q;
	bit          t_ok_q;
	logic [7:0]  h_hi_q;
	logic [7:0]  h_lo_q;

	reading_t expected_readings[$];
	reading_t pin_value;
	bit       pin_armed = 1'b0;

	int fail_count   = 0;
	int bytes_sent   = 0;
	int results_seen = 0;
	int n_ok         = 0;
	int n_temp_err   = 0;
	int n_hum_err    = 0;
	int idle_pct     = 0;
	int stall_pct    = 0;
	int idle_cycles  = 0;

	frame_row_t plan [6];

	humidity_temp_frame_decoder u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.rx_valid          (rx_valid),
		.rx_stall          (rx_stall),
		.rx_byte           (rx_byte),
		.frame_start       (frame_start),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.status            (status),
		.temperature_centi (temperature_centi),
		.humidity_centi    (humidity_centi),
		.temperature_word  (temperature_word),
		.humidity_word     (humidity_word)
	);

	always #1 clk = ~clk;

	// bitwise CRC-8, poly 0x31, MSB first
	function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		bit         fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ b[i];
			c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return c;
	endfunction

	// advance the mirrored decoder by one byte; return 1 when a reading is due
	function automatic bit decode_byte(input logic [7:0] b, input bit mark, output reading_t r);
		logic [2:0]  p;
		bit          h_ok;
		logic [15:0] hw;
		longint      tv;
		longint      hv;
		r = '0;
		p = (mark || pos_q > POS_RH_CRC) ? POS_T_MSB : pos_q;
		case (p)
			POS_T_MSB: begin
				crc_q   = crc_step(CRC_INIT, b);
				t_raw_q = {b, 8'h00};
			end
			POS_T_LSB: begin
				crc_q        = crc_step(crc_q, b);
				t_raw_q[7:0] = b;
			end
			POS_T_CRC: t_ok_q = (crc_q == b);
			POS_RH_MSB: begin
				crc_q  = crc_step(CRC_INIT, b);
				h_hi_q = b;
			end
			POS_RH_LSB: begin
				crc_q  = crc_step(crc_q, b);
				h_lo_q = b;
			end
			default: begin
				h_ok        = (crc_q == b);
				hw          = {h_hi_q, h_lo_q};
				r.temp_bits = t_raw_q;
				r.hum_raw   = hw;
				if (!t_ok_q) begin
					r.status = STATUS_TEMP_CRC;
				end else if (!h_ok) begin
					r.status = STATUS_HUM_CRC;
				end else begin
					r.status = STATUS_OK;
					tv       = (longint'(t_raw_q) * 17500) / 65535 - 4500;
					hv       = (longint'(hw) * 10000) / 65535;
					r.temp_c = tv[14:0];
					r.hum_c  = hv[13:0];
				end
				pos_q = POS_T_MSB;
				crc_q = CRC_INIT;
				return 1'b1;
			end
		endcase
		pos_q = p + 3'd1;
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s on reading %0d: got %0d, expected %0d",
			what, results_seen, got, want);
		fail_count++;
	endtask

	// predict on accepted bytes, check accepted readings
	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		reading_t got;
		if (!arst_n) begin
			pos_q   = POS_T_MSB;
			crc_q   = CRC_INIT;
			t_raw_q = '0;
			t_ok_q  = 1'b0;
			h_hi_q  = '0;
			h_lo_q  = '0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_readings.size() == 0) begin
					report_mismatch("unexpected reading, status", status, -1);
				end else begin
					want = expected_readings.pop_front();
					if (status !== want.status)
						report_mismatch("status", status, want.status);
					if (temperature_centi !== want.temp_c)
						report_mismatch("temperature_centi", temperature_centi, want.temp_c);
					if (humidity_centi !== want.hum_c)
						report_mismatch("humidity_centi", humidity_centi, want.hum_c);
					if (temperature_word !== want.temp_bits)
						report_mismatch("temperature_word", temperature_word, want.temp_bits);
					if (humidity_word !== want.hum_raw)
						report_mismatch("humidity_word", humidity_word, want.hum_raw);
					case (want.status)
						STATUS_OK:       n_ok++;
						STATUS_TEMP_CRC: n_temp_err++;
						default:         n_hum_err++;
					endcase
				end
				results_seen++;
			end
			if (rx_valid && !rx_stall) begin
				if (decode_byte(rx_byte, frame_start, got)) begin
					// a hand-typed reading replaces the prediction for table frames
					if (pin_armed) begin
						expected_readings.push_back(pin_value);
						pin_armed = 1'b0;
					end else begin
						expected_readings.push_back(got);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((rx_valid && !rx_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("Watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	// one request per call; hold the payload while stalled
	task automatic send_byte(input logic [7:0] b, input bit mark);
		while ($urandom_range(99) < idle_pct) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid    <= 1'b1;
		rx_byte     <= b;
		frame_start <= mark;
		do @(posedge clk); while (rx_stall);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [15:0] tw, input logic [15:0] hw, input bit bad_t,
		input bit bad_h, input bit mark, input int nbytes, input bit pinned,
		input reading_t pin_r);
		logic [7:0] frame_bytes [6];
		frame_bytes[0] = tw[15:8];
		frame_bytes[1] = tw[7:0];
		frame_bytes[2] = crc_step(crc_step(CRC_INIT, tw[15:8]), tw[7:0]);
		frame_bytes[3] = hw[15:8];
		frame_bytes[4] = hw[7:0];
		frame_bytes[5] = crc_step(crc_step(CRC_INIT, hw[15:8]), hw[7:0]);
		if (bad_t)
			frame_bytes[2] ^= 8'($urandom_range(1, 255));
		if (bad_h)
			frame_bytes[5] ^= 8'($urandom_range(1, 255));
		for (int i = 0; i < nbytes; i++) begin
			if (i == 5 && pinned) begin
				pin_value = pin_r;
				pin_armed = 1'b1;
			end
			send_byte(frame_bytes[i], mark && i == 0);
		end
	endtask

	// hold the sender until every reading in flight has come out
	task automatic drain_readings();
		rx_valid <= 1'b0;
		@(posedge clk);
		while (expected_readings.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [15:0] pick_word();
		case ($urandom_range(9))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'($urandom_range(3));
			3:       return 16'hFFFF - 16'($urandom_range(3));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_chunk();
		int kind;
		kind = $urandom_range(99);
		if (kind < 75) begin
			send_frame(pick_word(), pick_word(), $urandom_range(99) < 12,
				$urandom_range(99) < 12, $urandom_range(99) < 85, 6, 1'b0, '0);
		end else if (kind < 90) begin
			// broken frame: cut short, the next marked frame restarts it
			send_frame(pick_word(), pick_word(), 1'b0, 1'b0, 1'b1,
				$urandom_range(1, 5), 1'b0, '0);
		end else begin
			repeat ($urandom_range(1, 4))
				send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
		end
	endtask

	initial begin
		int phase_end;
		// t_word, h_word, bad_t, bad_h, mark, nbytes, pinned, typed reading
		plan[0] = '{16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1, 3'd6, 1'b1,
			'{STATUS_OK, -15'sd4500, 14'd10000, 16'h0000, 16'hFFFF}};
		// no start mark: relies on the wrap after the previous frame
		plan[1] = '{16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0, 3'd6, 1'b1,
			'{STATUS_OK, 15'sd13000, 14'd0, 16'hFFFF, 16'h0000}};
		plan[2] = '{16'hA5C3, 16'h5A3C, 1'b0, 1'b0, 1'b1, 3'd2, 1'b0, '0};
		plan[3] = '{16'h8000, 16'h7FFF, 1'b1, 1'b1, 1'b1, 3'd6, 1'b1,
			'{STATUS_TEMP_CRC, 15'sd0, 14'd0, 16'h8000, 16'h7FFF}};
		plan[4] = '{16'h6666, 16'h1234, 1'b1, 1'b0, 1'b1, 3'd6, 1'b1,
			'{STATUS_TEMP_CRC, 15'sd0, 14'd0, 16'h6666, 16'h1234}};
		plan[5] = '{16'h6666, 16'hBEEF, 1'b0, 1'b1, 1'b1, 3'd6, 1'b1,
			'{STATUS_HUM_CRC, 15'sd0, 14'd0, 16'h6666, 16'hBEEF}};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct  = 27;
		stall_pct = 47;
		foreach (plan[i])
			send_frame(plan[i].t_word, plan[i].h_word, plan[i].bad_t, plan[i].bad_h,
				plan[i].mark, int'(plan[i].nbytes), plan[i].pinned, plan[i].pin_reading);
		drain_readings();

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct  = (ph == 0) ? 27 : (ph == 1) ? 47 : 0;
			stall_pct = (ph == 0) ? 47 : (ph == 1) ? 27 : 0;
			phase_end = bytes_sent + RANDOM_PER_PHASE;
			while (bytes_sent < phase_end)
				random_chunk();
			drain_readings();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d frame bytes; checked %0d readings", bytes_sent, results_seen);
		$display("Readings: %0d good, %0d temperature CRC errors, %0d humidity CRC errors",
			n_ok, n_temp_err, n_hum_err);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
